// ===== rtl/dram_frfcfs_request_scheduler_top_macros.svh =====
// ----------------------------------------------------------------------------
// dram_frfcfs_request_scheduler_top_macros
// assertion helpers for the scheduler
// ----------------------------------------------------------------------------
`ifndef DRAM_FRFCFS_REQUEST_SCHEDULER_TOP_MACROS_SVH
`define DRAM_FRFCFS_REQUEST_SCHEDULER_TOP_MACROS_SVH
// assert an implication on aclk, off in reset
`define DFS_ASSERT_IMP(label, cond, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error("assertion failed");
// assert a next-cycle implication on aclk
`define DFS_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error("assertion failed");
`endif

// ===== rtl/dfs_pkg.sv =====
// ----------------------------------------------------------------------------
// dfs_pkg
// shared types and constants of the fr-fcfs request scheduler
// ----------------------------------------------------------------------------
package dfs_pkg;
    localparam int QueueDepth = 16;
    localparam int BankCount = 8;
    localparam int SlotW = $clog2(QueueDepth);
    localparam int CntW = $clog2(QueueDepth + 1);
    localparam int BankW = $clog2(BankCount);
    localparam int TimeW = 48;

    localparam logic [2:0] REG_POLICY = 3'd0;
    localparam logic [2:0] REG_ACT = 3'd1;
    localparam logic [2:0] REG_PRE = 3'd2;
    localparam logic [2:0] REG_RWCMD = 3'd3;
    localparam logic [2:0] REG_RWBANK = 3'd4;
    localparam logic [2:0] REG_RWDATA = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE, ST_RETIRE, ST_SHIFT, ST_PICK, ST_ISSUE, ST_OUT
    } state_t;

    typedef struct packed {
        logic       policy;
        logic [7:0] act;
        logic [7:0] pre;
        logic [7:0] rwcmd;
        logic [9:0] rwbank;
        logic [9:0] rwdata;
    } cfg_t;

    function automatic logic [BankW-1:0] bank_of(input logic [31:0] a);
        return a[5 +: BankW];
    endfunction

    function automatic logic [15:0] row_of(input logic [31:0] a);
        return a[31:16];
    endfunction
endpackage

// ===== rtl/dfs_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// dfs_cfg_regs
// apb timing and policy registers
// ----------------------------------------------------------------------------
module dfs_cfg_regs (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output dfs_pkg::cfg_t       cfg
);
    dfs_pkg::cfg_t cfg_reg;
    logic [2:0] idx;
    assign idx = paddr[4:2];
    assign pready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{policy: 1'b0, act: 8'd4, pre: 8'd4, rwcmd: 8'd4,
                         rwbank: 10'd100, rwdata: 10'd50};
        end else if (psel && penable && pwrite) begin
            case (idx)
                dfs_pkg::REG_POLICY: cfg_reg.policy <= pwdata[0];
                dfs_pkg::REG_ACT:    cfg_reg.act <= pwdata[7:0];
                dfs_pkg::REG_PRE:    cfg_reg.pre <= pwdata[7:0];
                dfs_pkg::REG_RWCMD:  cfg_reg.rwcmd <= pwdata[7:0];
                dfs_pkg::REG_RWBANK: cfg_reg.rwbank <= pwdata[9:0];
                dfs_pkg::REG_RWDATA: cfg_reg.rwdata <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            dfs_pkg::REG_POLICY: prdata = {31'd0, cfg_reg.policy};
            dfs_pkg::REG_ACT:    prdata = {24'd0, cfg_reg.act};
            dfs_pkg::REG_PRE:    prdata = {24'd0, cfg_reg.pre};
            dfs_pkg::REG_RWCMD:  prdata = {24'd0, cfg_reg.rwcmd};
            dfs_pkg::REG_RWBANK: prdata = {22'd0, cfg_reg.rwbank};
            dfs_pkg::REG_RWDATA: prdata = {22'd0, cfg_reg.rwdata};
            default:             prdata = 32'd0;
        endcase
    end
endmodule

// ===== rtl/dram_frfcfs_request_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// dram_frfcfs_request_scheduler_top
// fr-fcfs dram request queue and scheduler with serial slot scan
// ----------------------------------------------------------------------------
// One input transfer produces exactly one result transfer, and no new input is
// taken until that result transfer completes. An accepted enqueue writes its
// queue slot and the output register directly. A tick walks the 16-entry
// queue one slot per cycle, using 48-bit compares and adds on the slot fields. Its
// retire scan stops at the first completed request or at the end of the filled
// slots. A retirement is followed by a compaction pass that shifts the younger
// entries down, and the tick then ends. With no retirement and the command bus
// busy the tick ends after the retire scan; otherwise a pick scan over all
// slots and an issue step follow. The result sits in an output register.
`include "dram_frfcfs_request_scheduler_top_macros.svh"
module dram_frfcfs_request_scheduler_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [47:0] s_cycle,
    input  logic [31:0] s_address,
    input  logic        s_write,
    input  logic [3:0]  s_core,
    input  logic        s_source,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_accepted,
    output logic        m_done_valid,
    output logic [31:0] m_done_address,
    output logic        m_done_write,
    output logic [3:0]  m_done_core,
    output logic        m_done_source,
    output logic [47:0] m_done_time
);
    localparam int QD = dfs_pkg::QueueDepth;
    localparam int SW = dfs_pkg::SlotW;
    localparam int CW = dfs_pkg::CntW;
    localparam int BW = dfs_pkg::BankW;
    localparam int NB = dfs_pkg::BankCount;
    localparam int TW = dfs_pkg::TimeW;

    dfs_pkg::cfg_t cfg;

    dfs_cfg_regs u_cfg (
        .aclk(aclk), .aresetn(aresetn), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .cfg(cfg)
    );

    // queue state: slots 0..count-1 hold entries in age order
    logic [QD-1:0] sched_reg;
    logic [CW-1:0] count_reg;
    logic [31:0]   addr_mem [QD];
    logic          wr_mem   [QD];
    logic [3:0]    core_mem [QD];
    logic          src_mem  [QD];
    logic [TW-1:0] arr_mem  [QD];
    logic [TW-1:0] fin_mem  [QD];

    // bank and bus timing
    logic [NB-1:0] bopen_reg;
    logic [15:0]   brow_reg [NB];
    logic [TW-1:0] bfree_reg [NB];
    logic [TW-1:0] cmd_free_reg, data_free_reg;

    // sequencer
    dfs_pkg::state_t state_reg, state_next;
    logic [SW-1:0]   idx_reg;
    logic [TW-1:0]   cyc_reg;
    logic            best_ok_reg, best_hit_reg;
    logic [SW-1:0]   best_reg;
    logic [TW-1:0]   best_arr_reg;
    logic            best_src_reg;

    // output register
    logic        ov_reg, oacc_reg, odv_reg, owr_reg, osrc_reg;
    logic [31:0] oaddr_reg;
    logic [3:0]  ocore_reg;
    logic [TW-1:0] otime_reg;

    assign s_ready = (state_reg == dfs_pkg::ST_IDLE);
    assign m_valid = ov_reg;
    assign m_accepted = oacc_reg;
    assign m_done_valid = odv_reg;
    assign m_done_address = oaddr_reg;
    assign m_done_write = owr_reg;
    assign m_done_core = ocore_reg;
    assign m_done_source = osrc_reg;
    assign m_done_time = otime_reg;

    // current slot view and latency figures
    logic          in_q, last;
    logic [31:0]   sa;
    logic [BW-1:0] sb;
    logic          shit, eff_hit;
    logic [TW-1:0] hit_lat, act_lat, conf_lat, off, cand_t;
    logic          cand_ok, better;

    assign in_q = ({1'b0, idx_reg} < count_reg);
    assign last = (idx_reg == SW'(QD - 1));
    assign sa = addr_mem[idx_reg];
    assign sb = dfs_pkg::bank_of(sa);
    assign shit = bopen_reg[sb] && (brow_reg[sb] == dfs_pkg::row_of(sa));
    assign hit_lat = TW'(cfg.rwcmd) + TW'(cfg.rwbank);
    assign act_lat = hit_lat + TW'(cfg.act);
    assign conf_lat = act_lat + TW'(cfg.pre);

    always_comb begin
        if (!cfg.policy && shit) off = hit_lat;
        else if (bopen_reg[sb]) off = conf_lat;
        else off = act_lat;
    end

    // the candidate-time adder feeds the data bus check
    assign cand_t = cyc_reg + off;
    assign eff_hit = shit && !cfg.policy;
    assign cand_ok = in_q && !sched_reg[idx_reg] && !(cyc_reg < bfree_reg[sb])
                     && !(cand_t < data_free_reg);
    always_comb begin
        if (!best_ok_reg) better = 1'b1;
        else if (eff_hit != best_hit_reg) better = eff_hit;
        else if (arr_mem[idx_reg] < best_arr_reg) better = 1'b1;
        else better = (arr_mem[idx_reg] == best_arr_reg) && src_mem[idx_reg]
                      && !best_src_reg;
    end

    logic retire_hit;
    assign retire_hit = in_q && sched_reg[idx_reg] && !(cyc_reg < fin_mem[idx_reg]);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dfs_pkg::ST_IDLE:
                if (s_valid) state_next = s_kind ? dfs_pkg::ST_RETIRE : dfs_pkg::ST_OUT;
            dfs_pkg::ST_RETIRE:
                if (retire_hit) state_next = dfs_pkg::ST_SHIFT;
                else if (last || !in_q) begin
                    state_next = (cyc_reg < cmd_free_reg) ? dfs_pkg::ST_OUT
                                                          : dfs_pkg::ST_PICK;
                end
            dfs_pkg::ST_SHIFT:
                if (last) state_next = dfs_pkg::ST_OUT;
            dfs_pkg::ST_PICK:
                if (last) state_next = dfs_pkg::ST_ISSUE;
            dfs_pkg::ST_ISSUE:
                state_next = dfs_pkg::ST_OUT;
            dfs_pkg::ST_OUT:
                if (ov_reg && m_ready) state_next = dfs_pkg::ST_IDLE;
            default: state_next = dfs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= dfs_pkg::ST_IDLE;
        else state_reg <= state_next;
    end

    // issue-time figures for the chosen slot
    logic [31:0]   wa;
    logic [BW-1:0] wb;
    logic [15:0]   wrow;
    logic          whit;
    logic [TW-1:0] lat;
    assign wa = addr_mem[best_reg];
    assign wb = dfs_pkg::bank_of(wa);
    assign wrow = dfs_pkg::row_of(wa);
    assign whit = bopen_reg[wb] && (brow_reg[wb] == wrow);
    always_comb begin
        if (!cfg.policy && whit) lat = hit_lat;
        else if (bopen_reg[wb]) lat = conf_lat;
        else lat = act_lat;
    end

    logic [SW-1:0] nxt;
    assign nxt = last ? idx_reg : idx_reg + SW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sched_reg <= '0;
            count_reg <= '0;
            bopen_reg <= '0;
            for (int b = 0; b < NB; b++) begin
                brow_reg[b] <= '0;
                bfree_reg[b] <= '0;
            end
            cmd_free_reg <= '0;
            data_free_reg <= '0;
            ov_reg <= 1'b0;
            idx_reg <= '0;
            best_ok_reg <= 1'b0;
        end else begin
            case (state_reg)
                dfs_pkg::ST_IDLE: begin
                    idx_reg <= '0;
                    best_ok_reg <= 1'b0;
                    cyc_reg <= s_cycle;
                    oacc_reg <= s_valid && !s_kind && (count_reg != CW'(QD));
                    odv_reg <= 1'b0;
                    oaddr_reg <= '0;
                    owr_reg <= 1'b0;
                    ocore_reg <= '0;
                    osrc_reg <= 1'b0;
                    otime_reg <= '0;
                    if (s_valid && !s_kind) begin
                        ov_reg <= 1'b1;
                        if (count_reg != CW'(QD)) begin
                            addr_mem[count_reg[SW-1:0]] <= s_address;
                            wr_mem[count_reg[SW-1:0]] <= s_write;
                            core_mem[count_reg[SW-1:0]] <= s_core;
                            src_mem[count_reg[SW-1:0]] <= s_source;
                            arr_mem[count_reg[SW-1:0]] <= s_cycle;
                            fin_mem[count_reg[SW-1:0]] <= '0;
                            sched_reg[count_reg[SW-1:0]] <= 1'b0;
                            count_reg <= count_reg + CW'(1);
                        end
                    end
                end
                dfs_pkg::ST_RETIRE: begin
                    if (retire_hit) begin
                        odv_reg <= 1'b1;
                        oaddr_reg <= sa;
                        owr_reg <= wr_mem[idx_reg];
                        ocore_reg <= core_mem[idx_reg];
                        osrc_reg <= src_mem[idx_reg];
                        otime_reg <= fin_mem[idx_reg];
                        count_reg <= count_reg - CW'(1);
                    end else if (last || !in_q) begin
                        idx_reg <= '0;
                        if (cyc_reg < cmd_free_reg) ov_reg <= 1'b1;
                    end else begin
                        idx_reg <= nxt;
                    end
                    if (retire_hit && last) sched_reg[idx_reg] <= 1'b0;
                end
                dfs_pkg::ST_SHIFT: begin
                    // move the younger entry down one place
                    if (!last) begin
                        addr_mem[idx_reg] <= addr_mem[nxt];
                        wr_mem[idx_reg] <= wr_mem[nxt];
                        core_mem[idx_reg] <= core_mem[nxt];
                        src_mem[idx_reg] <= src_mem[nxt];
                        arr_mem[idx_reg] <= arr_mem[nxt];
                        fin_mem[idx_reg] <= fin_mem[nxt];
                        sched_reg[idx_reg] <= sched_reg[nxt];
                    end else begin
                        sched_reg[idx_reg] <= 1'b0;
                        ov_reg <= 1'b1;
                    end
                    idx_reg <= nxt;
                end
                dfs_pkg::ST_PICK: begin
                    if (cand_ok && better) begin
                        best_ok_reg <= 1'b1;
                        best_reg <= idx_reg;
                        best_hit_reg <= eff_hit;
                        best_arr_reg <= arr_mem[idx_reg];
                        best_src_reg <= src_mem[idx_reg];
                    end
                    idx_reg <= nxt;
                end
                dfs_pkg::ST_ISSUE: begin
                    ov_reg <= 1'b1;
                    if (best_ok_reg) begin
                        if (!cfg.policy) begin
                            if (whit) begin
                                cmd_free_reg <= cyc_reg + TW'(cfg.rwcmd);
                                bfree_reg[wb] <= cyc_reg + hit_lat;
                            end else if (bopen_reg[wb]) begin
                                cmd_free_reg <= cyc_reg + TW'(cfg.pre);
                                bfree_reg[wb] <= cyc_reg + conf_lat;
                                brow_reg[wb] <= wrow;
                            end else begin
                                cmd_free_reg <= cyc_reg + TW'(cfg.act);
                                bfree_reg[wb] <= cyc_reg + act_lat;
                                bopen_reg[wb] <= 1'b1;
                                brow_reg[wb] <= wrow;
                            end
                        end else begin
                            bopen_reg[wb] <= 1'b0;
                            if (bopen_reg[wb]) begin
                                cmd_free_reg <= cyc_reg + TW'(cfg.pre);
                                bfree_reg[wb] <= cyc_reg + conf_lat + TW'(cfg.pre);
                            end else begin
                                cmd_free_reg <= cyc_reg + TW'(cfg.act);
                                bfree_reg[wb] <= cyc_reg + act_lat + TW'(cfg.pre);
                                brow_reg[wb] <= wrow;
                            end
                        end
                        data_free_reg <= cyc_reg + lat + TW'(cfg.rwdata);
                        fin_mem[best_reg] <= cyc_reg + lat + TW'(cfg.rwdata);
                        sched_reg[best_reg] <= 1'b1;
                    end
                end
                dfs_pkg::ST_OUT: begin
                    if (ov_reg && m_ready) ov_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // a result is only offered while the sequencer waits in its output state
    `DFS_ASSERT_IMP(a_out_state, m_valid, state_reg == dfs_pkg::ST_OUT)
    // queue fill never exceeds depth
    `DFS_ASSERT_IMP(a_count, 1'b1, count_reg <= CW'(QD))
    // an enqueue result never reports a retirement
    `DFS_ASSERT_IMP(a_enq_res, m_valid && m_accepted, !m_done_valid)
    // a stalled result stays offered
    `DFS_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid)
endmodule
